// ----- sv/sfs_pkg.sv -----
package sfs_pkg;

  // Field widths, fixed by the stream and register formats
  localparam int DT_W      = 16;
  localparam int CLIPNUM_W = 4;
  localparam int CNT_W     = 7;
  localparam int DUR_W     = 16;
  localparam int MODE_W    = 2;
  localparam int FRAME_W   = 6;
  localparam int CLIP_W    = 5;
  localparam int ACC_W     = 48;
  localparam int ADD_W     = DT_W + CNT_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam int FRAMES_MAX   = 64;
  localparam int DT_FRAC_BITS = 8;

  localparam logic [CLIP_W-1:0] NO_CLIP = CLIP_W'(31);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT   = 2'd0,
    REG_CLIP_DURATION = 2'd1,
    REG_PLAY_MODE     = 2'd2,
    REG_CLIP_VALID    = 2'd3
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOP     = 2'd0,
    MODE_PINGPONG = 2'd1,
    MODE_ONCE     = 2'd2
  } play_mode_e;

  typedef enum logic {
    ACT_TICK   = 1'b0,
    ACT_SELECT = 1'b1
  } action_e;

  typedef struct packed {
    logic [CNT_W-1:0]  frame_count;
    logic [DUR_W-1:0]  clip_duration;
    logic [MODE_W-1:0] play_mode;
    logic              clip_valid;
  } cfg_t;

  typedef struct packed {
    logic                 action;
    logic [DT_W-1:0]      delta_time;
    logic [CLIPNUM_W-1:0] clip_number;
  } item_t;

  typedef struct packed {
    logic [ACC_W-1:0]   acc;
    logic [FRAME_W-1:0] frame;
    logic               finished;
    logic [CLIP_W-1:0]  clip;
  } state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               done_res;
    logic               active;
  } result_t;

endpackage

// ----- sv/sprite_frame_sequencer_top.sv -----
// Sprite animation frame timer.
// Input stream (s_axis): each word is either a time tick (tuser = 0) carrying
// elapsed milliseconds with 8 fraction bits, or a clip select (tuser = 1)
// carrying a clip number. A select restarts the animation only when the clip
// number differs from the current one.
// Output stream (m_axis): exactly one word per input word, giving the current
// frame index, the finished flag of a play-once clip and whether the tick ran.
// Configuration: cfg_we/cfg_index/cfg_data write frame count, clip duration,
// play mode and clip valid; write them only while the block is idle.
// Path: the input register takes the word at the accepting edge, and the
// result register takes its result on advance, which raises output valid.
// Throughput: one word per cycle while m_axis_tready is high; the multiply,
// saturating add, compare and subtract of a tick fit in the single stage
// between the input register and the result register, which also updates
// the animation state.
// Reset (rst, synchronous): both stages empty, no clip selected, frame 0,
// accumulator cleared, registers back to their defaults (play once).
// Stall: when m_axis_tready is low the result is held, one more word can wait
// in the input register, and then s_axis_tready drops.
module sprite_frame_sequencer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] delta_time, [19:16] clip_number, [23:20] zero
  input  logic [23:0]                     s_axis_tdata,
  // [0] action
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [5:0] frame_index, [6] done_res, [7] active
  output logic [7:0]                      m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfs_pkg::CFG_W-1:0]       cfg_data
);

  sfs_pkg::cfg_t    cfg;
  sfs_pkg::state_t  state;
  sfs_pkg::state_t  state_next;
  sfs_pkg::item_t   s1_item;
  sfs_pkg::result_t res_next;
  sfs_pkg::result_t out_res;
  logic             s1_valid;
  logic             out_valid;
  logic             advance;
  logic             accept;

  // Advance the input register whenever the result register is free or drains.
  assign advance = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_count   <= '0;
      cfg.clip_duration <= '0;
      cfg.play_mode     <= sfs_pkg::MODE_ONCE;
      cfg.clip_valid    <= 1'b0;
    end else if (cfg_we) begin
      unique case (sfs_pkg::cfg_reg_e'(cfg_index))
        sfs_pkg::REG_FRAME_COUNT:   cfg.frame_count   <= cfg_data[sfs_pkg::CNT_W-1:0];
        sfs_pkg::REG_CLIP_DURATION: cfg.clip_duration <= cfg_data[sfs_pkg::DUR_W-1:0];
        sfs_pkg::REG_PLAY_MODE:     cfg.play_mode     <= cfg_data[sfs_pkg::MODE_W-1:0];
        sfs_pkg::REG_CLIP_VALID:    cfg.clip_valid    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_item.action      <= s_axis_tuser;
      s1_item.delta_time  <= s_axis_tdata[15:0];
      s1_item.clip_number <= s_axis_tdata[19:16];
    end
  end

  sfs_step u_step (
    .cfg        (cfg),
    .item       (s1_item),
    .state      (state),
    .state_next (state_next),
    .result     (res_next)
  );

  // Animation state and result register: update together on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.acc      <= '0;
      state.frame    <= '0;
      state.finished <= 1'b0;
      state.clip     <= sfs_pkg::NO_CLIP;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.active, out_res.done_res, out_res.frame_index};

`ifndef NO_ASSERTIONS
  // With no clip selected the sequence must stay at its cleared state.
  a_no_clip_clear: assert property (@(posedge clk) disable iff (rst)
    (state.clip == sfs_pkg::NO_CLIP) |->
      (state.frame == '0 && !state.finished && state.acc == '0))
    else $error("state moved with no clip selected");

  // A stalled result must not be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !advance)
    else $error("result register overwritten while stalled");

  // Both stages full and stalled: input must be back-pressured.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted with both stages full");

  // The state only changes when an item is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without an item");
`endif

endmodule

// ----- sv/sfs_step.sv -----
// One item against the sequencer state: select or timed advance.
module sfs_step (
  input  sfs_pkg::cfg_t    cfg,
  input  sfs_pkg::item_t   item,
  input  sfs_pkg::state_t  state,
  output sfs_pkg::state_t  state_next,
  output sfs_pkg::result_t result
);

  logic [sfs_pkg::CNT_W-1:0]   frames;
  logic [sfs_pkg::ADD_W-1:0]   add;
  logic [sfs_pkg::ACC_W:0]     sum;
  logic [sfs_pkg::ACC_W-1:0]   acc_sat;
  logic [sfs_pkg::ACC_W-1:0]   thr;
  logic [sfs_pkg::CNT_W-1:0]   frame_inc;
  logic                        tick_ok;
  logic                        due;
  logic                        wrap_mode;

  always_comb begin
    frames = (cfg.frame_count > sfs_pkg::CNT_W'(sfs_pkg::FRAMES_MAX)) ?
             sfs_pkg::CNT_W'(sfs_pkg::FRAMES_MAX) : cfg.frame_count;
    tick_ok = (state.clip != sfs_pkg::NO_CLIP) && cfg.clip_valid &&
              (frames != '0) && (cfg.clip_duration != '0);
    add = sfs_pkg::ADD_W'(item.delta_time) * sfs_pkg::ADD_W'(frames);
    sum = {1'b0, state.acc} + (sfs_pkg::ACC_W+1)'(add);
    // saturate instead of wrapping
    acc_sat = sum[sfs_pkg::ACC_W] ? '1 : sum[sfs_pkg::ACC_W-1:0];
    thr = sfs_pkg::ACC_W'(cfg.clip_duration) << sfs_pkg::DT_FRAC_BITS;
    due = acc_sat >= thr;
    frame_inc = {1'b0, state.frame} + sfs_pkg::CNT_W'(1);
    wrap_mode = (cfg.play_mode == sfs_pkg::MODE_LOOP) ||
                (cfg.play_mode == sfs_pkg::MODE_PINGPONG);

    state_next = state;
    result.done_res = 1'b0;
    result.active = 1'b0;

    if (item.action == sfs_pkg::ACT_SELECT) begin
      if ({1'b0, item.clip_number} != state.clip) begin
        state_next.clip = {1'b0, item.clip_number};
        state_next.frame = '0;
        state_next.acc = '0;
        state_next.finished = 1'b0;
      end
      result.done_res = state_next.finished;
    end else if (tick_ok) begin
      state_next.acc = acc_sat;
      if (due) begin
        state_next.acc = acc_sat - thr;
        if (frame_inc >= frames) begin
          if (wrap_mode) begin
            state_next.frame = '0;
          end else begin
            // hold the last frame
            state_next.frame = sfs_pkg::FRAME_W'(frames - sfs_pkg::CNT_W'(1));
            state_next.finished = 1'b1;
          end
        end else begin
          state_next.frame = sfs_pkg::FRAME_W'(frame_inc);
        end
      end
      result.done_res = state_next.finished;
      result.active = 1'b1;
    end
    result.frame_index = state_next.frame;
  end

endmodule
